>>> sv/rcss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and distribute-point tables for the relay card scan sequencer.
package rcss_pkg;

  localparam int GROUPS         = 9;
  localparam int ROWS_PER_GROUP = 16;
  localparam int MAX_RES        = 3;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);
  localparam int CACHE_ROWS     = 4;

  localparam logic [3:0]  TRANSFER_POINT = 4'd9;
  localparam logic [3:0]  NUM_POINTS     = 4'd10;
  localparam logic [15:0] TIMEOUT_WORD   = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_WORD  = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_WAIT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    REG_POLL_WAIT     = 2'd0,
    REG_DEBOUNCE_WAIT = 2'd1,
    REG_STEP_WAIT     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] poll_wait_ms;
    logic [7:0] debounce_wait_ms;
    logic [7:0] step_wait_ms;
  } rcss_cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  row;
    logic [5:0]  write_data;
    logic [15:0] card_word;
    logic [3:0]  card_group;
    logic [7:0]  wait_ms;
    logic        last;
  } rcss_res_t;

  // Cache row that holds a distribute point.
  function automatic logic [1:0] dist_row(input logic [3:0] p);
    logic [1:0] r;
    begin
      case (p)
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4: r = 2'd0;
        4'd5, 4'd6, 4'd7, 4'd8, 4'd9: r = 2'd1;
        default:                      r = 2'd0;
      endcase
      return r;
    end
  endfunction

  // Bit position of a distribute point inside its cache row.
  function automatic logic [2:0] dist_col(input logic [3:0] p);
    logic [2:0] c;
    begin
      case (p)
        4'd0, 4'd5: c = 3'd4;
        4'd1, 4'd6: c = 3'd3;
        4'd2, 4'd7: c = 3'd2;
        4'd3, 4'd8: c = 3'd1;
        4'd4:       c = 3'd0;
        4'd9:       c = 3'd5;
        default:    c = 3'd4;
      endcase
      return c;
    end
  endfunction

  function automatic rcss_res_t mk_res(input kind_e k, input logic [3:0] row,
                                       input logic [5:0] wd, input logic [15:0] word,
                                       input logic [3:0] grp, input logic [7:0] wt);
    rcss_res_t r;
    begin
      r.kind       = k;
      r.row        = row;
      r.write_data = wd;
      r.card_word  = word;
      r.card_group = grp;
      r.wait_ms    = wt;
      r.last       = 1'b0;
      return r;
    end
  endfunction

endpackage

>>> sv/relay_card_scan_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the relay card scan sequencer: config registers, input register and datapath.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------------------
//   in       | in        | in_valid_i / in_stall_o   | op_i, read_data_i, timed_out_i
//   out      | out       | out_valid_o / out_stall_i | kind_o, row_o, write_data_o,
//            |           |                           | card_word_o, card_group_o, wait_ms_o,
//            |           |                           | last_o
//   cfg      | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item is held in the input register, then the state machine steps on it and
// drops its 0 to 3 results into a four-entry result queue. Items enter one
// per cycle while the queue has space for three more results; the output drains
// one result per cycle while out_stall_i is low.
// Reset is asynchronous, active low, and leaves the block idle with default waits.
// cfg_ready_o is always high.
module relay_card_scan_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [9:0]  read_data_i,
  input  logic        timed_out_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  row_o,
  output logic [5:0]  write_data_o,
  output logic [15:0] card_word_o,
  output logic [3:0]  card_group_o,
  output logic [7:0]  wait_ms_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import rcss_pkg::*;

  rcss_cfg_t  cfg_q;
  logic       in_vld_q;
  logic       op_q;
  logic [9:0] rd_q;
  logic       to_q;
  logic       load;
  logic       fire;
  logic       room;
  logic [15:0] val;
  rcss_res_t [MAX_RES-1:0] res;
  logic [1:0] res_n;
  rcss_res_t  head;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_vld_q && room;
  assign in_stall_o  = in_vld_q && !room;
  assign load        = in_valid_i && !in_stall_o;
  assign val         = to_q ? TIMEOUT_WORD : {6'd0, rd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_wait_ms     <= 8'd100;
      cfg_q.debounce_wait_ms <= 8'd64;
      cfg_q.step_wait_ms     <= 8'd32;
      in_vld_q               <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_POLL_WAIT:     cfg_q.poll_wait_ms     <= cfg_data_i;
          REG_DEBOUNCE_WAIT: cfg_q.debounce_wait_ms <= cfg_data_i;
          REG_STEP_WAIT:     cfg_q.step_wait_ms     <= cfg_data_i;
          default:           ;
        endcase
      end
      if (load) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q <= op_i;
      rd_q <= read_data_i;
      to_q <= timed_out_i;
    end
  end

  rcss_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .op_i    (op_q),
    .val_i   (val),
    .cfg_i   (cfg_q),
    .res_o   (res),
    .res_n_o (res_n)
  );

  rcss_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_n_i     (res_n),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o       = head.kind;
  assign row_o        = head.row;
  assign write_data_o = head.write_data;
  assign card_word_o  = head.card_word;
  assign card_group_o = head.card_group;
  assign wait_ms_o    = head.wait_ms;
  assign last_o       = head.last;

endmodule

>>> sv/rcss_seq.sv
`timescale 1ns / 1ps
// Scan state machine: turns one registered item into up to three results per cycle.
module rcss_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 fire_i,
  input  logic                                 op_i,
  input  logic [15:0]                          val_i,
  input  rcss_pkg::rcss_cfg_t                  cfg_i,
  output rcss_pkg::rcss_res_t [rcss_pkg::MAX_RES-1:0] res_o,
  output logic [1:0]                           res_n_o
);
  import rcss_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_SET      = 3'd2,
    PH_READ     = 3'd3,
    PH_TRANSMIT = 3'd4,
    PH_RELEASE  = 3'd5
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] grp_q, grp_d;
  logic [4:0] rc_q, rc_d;
  logic       aw_q, aw_d;
  logic       conf_q, conf_d;
  logic [5:0] cache_q [CACHE_ROWS];

  logic       cache_we;
  logic [3:0] pt_raw, pt;
  logic       pt_val;
  logic [1:0] wr_row;
  logic [2:0] wr_col;
  logic [5:0] wr_data;
  logic [4:0] rc_inc;
  logic [1:0] n;
  rcss_res_t  res [MAX_RES];

  // Distribute point touched by this step, and its updated cache row.
  always_comb begin
    pt_raw  = (phase_q == PH_TRANSMIT || phase_q == PH_RELEASE) ? TRANSFER_POINT : grp_q;
    pt      = (pt_raw < NUM_POINTS) ? pt_raw : 4'd0;
    pt_val  = (phase_q == PH_SET || phase_q == PH_TRANSMIT);
    wr_row  = dist_row(pt);
    wr_col  = dist_col(pt);
    wr_data = (cache_q[wr_row] & ~(6'd1 << wr_col)) | ({5'd0, pt_val} << wr_col);
  end

  assign rc_inc = rc_q + 5'd1;

  always_comb begin
    phase_d  = phase_q;
    grp_d    = grp_q;
    rc_d     = rc_q;
    aw_d     = aw_q;
    conf_d   = conf_q;
    cache_we = 1'b0;
    n        = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = mk_res(KIND_READ, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
    end

    case (phase_q)
      PH_IDLE: begin
        if (!op_i && !aw_q) begin
          res[0] = mk_res(KIND_READ, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
          n      = 2'd1;
          aw_d   = 1'b1;
        end else if (op_i && aw_q) begin
          aw_d = 1'b0;
          n    = 2'd1;
          if (val_i[8] || val_i[9]) begin
            phase_d = PH_DEBOUNCE;
            res[0]  = mk_res(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, cfg_i.debounce_wait_ms);
          end else begin
            res[0]  = mk_res(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, cfg_i.poll_wait_ms);
          end
        end
      end
      PH_DEBOUNCE: begin
        if (!op_i && !aw_q) begin
          res[0] = mk_res(KIND_READ, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
          n      = 2'd1;
          aw_d   = 1'b1;
          conf_d = 1'b0;
        end else if (op_i && aw_q) begin
          n = 2'd1;
          if (!conf_q && val_i[9]) begin
            aw_d    = 1'b0;
            phase_d = PH_SET;
            grp_d   = 4'(GROUPS - 1);
            res[0]  = mk_res(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, cfg_i.poll_wait_ms);
          end else if (!conf_q) begin
            conf_d = 1'b1;
            res[0] = mk_res(KIND_READ, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
          end else begin
            aw_d   = 1'b0;
            conf_d = 1'b0;
            if (val_i[8]) begin
              phase_d = PH_SET;
              grp_d   = 4'(GROUPS - 1);
            end else begin
              phase_d = PH_IDLE;
            end
            res[0] = mk_res(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, cfg_i.poll_wait_ms);
          end
        end
      end
      PH_SET: begin
        if (!op_i && !aw_q) begin
          cache_we = 1'b1;
          res[0]   = mk_res(KIND_WRITE, {2'd0, wr_row}, wr_data, 16'd0, 4'd0, 8'd0);
          res[1]   = mk_res(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, cfg_i.step_wait_ms);
          n        = 2'd2;
          phase_d  = PH_READ;
        end else if (op_i && aw_q) begin
          aw_d = 1'b0;
        end
      end
      PH_READ: begin
        if (!op_i && !aw_q) begin
          rc_d   = 5'd0;
          res[0] = mk_res(KIND_READ, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
          n      = 2'd1;
          aw_d   = 1'b1;
        end else if (op_i && aw_q) begin
          res[0] = mk_res(KIND_WORD, rc_q[3:0], 6'd0, val_i, grp_q, 8'd0);
          if (rc_inc < 5'(ROWS_PER_GROUP)) begin
            rc_d   = rc_inc;
            res[1] = mk_res(KIND_READ, rc_inc[3:0], 6'd0, 16'd0, 4'd0, 8'd0);
            n      = 2'd2;
          end else begin
            // Last row of the group: drop the distribute bit, move on.
            aw_d     = 1'b0;
            rc_d     = 5'd0;
            cache_we = 1'b1;
            res[1]   = mk_res(KIND_WRITE, {2'd0, wr_row}, wr_data, 16'd0, 4'd0, 8'd0);
            res[2]   = mk_res(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, cfg_i.step_wait_ms);
            n        = 2'd3;
            if (grp_q == 4'd0) begin
              phase_d = PH_TRANSMIT;
            end else begin
              grp_d   = grp_q - 4'd1;
              phase_d = PH_SET;
            end
          end
        end
      end
      PH_TRANSMIT: begin
        if (!op_i && !aw_q) begin
          cache_we = 1'b1;
          res[0]   = mk_res(KIND_WRITE, {2'd0, wr_row}, wr_data, 16'd0, 4'd0, 8'd0);
          res[1]   = mk_res(KIND_DONE, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
          res[2]   = mk_res(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, cfg_i.step_wait_ms);
          n        = 2'd3;
          phase_d  = PH_RELEASE;
        end else if (op_i && aw_q) begin
          aw_d = 1'b0;
        end
      end
      PH_RELEASE: begin
        if (!op_i && !aw_q) begin
          cache_we = 1'b1;
          res[0]   = mk_res(KIND_WRITE, {2'd0, wr_row}, wr_data, 16'd0, 4'd0, 8'd0);
          res[1]   = mk_res(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, cfg_i.step_wait_ms);
          n        = 2'd2;
          phase_d  = PH_IDLE;
          grp_d    = 4'(GROUPS - 1);
        end else if (op_i && aw_q) begin
          aw_d = 1'b0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        aw_d    = 1'b0;
      end
    endcase

    for (int i = 0; i < MAX_RES; i++) begin
      res[i].last = (n == 2'(i + 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      grp_q   <= 4'(GROUPS - 1);
      rc_q    <= 5'd0;
      aw_q    <= 1'b0;
      conf_q  <= 1'b0;
      for (int i = 0; i < CACHE_ROWS; i++) begin
        cache_q[i] <= 6'd0;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      grp_q   <= grp_d;
      rc_q    <= rc_d;
      aw_q    <= aw_d;
      conf_q  <= conf_d;
      if (cache_we) begin
        cache_q[wr_row] <= wr_data;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_o[i] = res[i];
    end
  end

  assign res_n_o = fire_i ? n : 2'd0;

endmodule

>>> sv/rcss_out_queue.sv
`timescale 1ns / 1ps
// Result queue: takes up to three results per cycle and hands out one per cycle while out_stall_i is low.
module rcss_out_queue (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rcss_pkg::rcss_res_t [rcss_pkg::MAX_RES-1:0] res_i,
  input  logic [1:0]                           res_n_i,
  output logic                                 room_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output rcss_pkg::rcss_res_t                  head_o
);
  import rcss_pkg::*;

  rcss_res_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic [QCNT_W-1:0]  cnt_after_pop;
  logic               pop;

  assign out_valid_o   = (cnt_q != '0);
  assign pop           = out_valid_o && !out_stall_i;
  assign head_o        = mem_q[rd_ptr_q];
  assign cnt_after_pop = cnt_q - QCNT_W'(pop);
  // Take a new item only if a full set of results still fits.
  assign room_o        = (cnt_after_pop <= QCNT_W'(QDEPTH - MAX_RES));

  assign wr_ptr_d = wr_ptr_q + QPTR_W'(res_n_i);
  assign rd_ptr_d = rd_ptr_q + QPTR_W'(pop);
  assign cnt_d    = cnt_after_pop + QCNT_W'(res_n_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < res_n_i) begin
        mem_q[wr_ptr_q + QPTR_W'(i)] <= res_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> tb/scan_result_checker.sv
`timescale 1ns / 1ps
// Checker for the relay card scan sequencer: predicts results of accepted items and compares.
module scan_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        op_i,
  input  logic [9:0]  read_data_i,
  input  logic        timed_out_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  row_i,
  input  logic [5:0]  write_data_i,
  input  logic [15:0] card_word_i,
  input  logic [3:0]  card_group_i,
  input  logic [7:0]  wait_ms_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output logic        reply_due_o
);
  import rcss_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DEBOUNCE,
    SEQ_SET,
    SEQ_READ,
    SEQ_TRANSMIT,
    SEQ_RELEASE
  } seq_phase_e;

  localparam logic [3:0] TOP_GROUP = 4'(GROUPS - 1);

  seq_phase_e  phase;
  logic [3:0]  group_idx;
  logic [4:0]  row_cnt;
  logic        awaiting;
  logic        second_read;
  logic [5:0]  dist_cache [CACHE_ROWS];
  logic [7:0]  poll_wait;
  logic [7:0]  debounce_wait;
  logic [7:0]  step_wait;

  rcss_res_t   staged [MAX_RES];
  int          staged_n;
  rcss_res_t   expected_results [$];
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic stage(input kind_e k, input logic [3:0] row, input logic [5:0] wd,
                       input logic [15:0] word, input logic [3:0] grp, input logic [7:0] wt);
    rcss_res_t r;
    r.kind       = k;
    r.row        = row;
    r.write_data = wd;
    r.card_word  = word;
    r.card_group = grp;
    r.wait_ms    = wt;
    r.last       = 1'b0;
    staged[staged_n] = r;
    staged_n++;
  endtask

  // Points 0-4 live in cache row 0 and 5-9 in row 1; the transfer point takes bit 5.
  task automatic write_point(input logic [3:0] point, input logic on);
    logic [1:0] r;
    logic [2:0] c;
    r = (point >= 4'd5) ? 2'd1 : 2'd0;
    c = (point == TRANSFER_POINT) ? 3'd5 : 3'(4 - (point % 5));
    dist_cache[r][c] = on;
    stage(KIND_WRITE, {2'b00, r}, dist_cache[r], 16'd0, 4'd0, 8'd0);
  endtask

  task automatic predict_item(input logic op, input logic [9:0] rd, input logic to);
    logic [15:0] val;
    logic [3:0]  grp;
    rcss_res_t   r;
    val = to ? TIMEOUT_WORD : {6'd0, rd};
    grp = group_idx;
    staged_n = 0;
    if (!op) begin
      // drop ticks while a row reply is outstanding
      if (!awaiting) begin
        case (phase)
          SEQ_IDLE, SEQ_DEBOUNCE: begin
            stage(KIND_READ, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
            awaiting = 1'b1;
            second_read = 1'b0;
          end
          SEQ_SET: begin
            write_point(grp, 1'b1);
            stage(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, step_wait);
            phase = SEQ_READ;
          end
          SEQ_READ: begin
            row_cnt = 5'd0;
            stage(KIND_READ, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
            awaiting = 1'b1;
          end
          SEQ_TRANSMIT: begin
            write_point(TRANSFER_POINT, 1'b1);
            stage(KIND_DONE, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
            stage(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, step_wait);
            phase = SEQ_RELEASE;
          end
          default: begin
            write_point(TRANSFER_POINT, 1'b0);
            stage(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, step_wait);
            phase = SEQ_IDLE;
            group_idx = TOP_GROUP;
          end
        endcase
      end
    end else if (awaiting) begin
      case (phase)
        SEQ_IDLE: begin
          awaiting = 1'b0;
          if (val[8] || val[9]) begin
            phase = SEQ_DEBOUNCE;
            stage(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, debounce_wait);
          end else begin
            stage(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, poll_wait);
          end
        end
        SEQ_DEBOUNCE: begin
          if (!second_read && val[9]) begin
            awaiting = 1'b0;
            phase = SEQ_SET;
            group_idx = TOP_GROUP;
            stage(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, poll_wait);
          end else if (!second_read) begin
            second_read = 1'b1;
            stage(KIND_READ, 4'd0, 6'd0, 16'd0, 4'd0, 8'd0);
          end else begin
            awaiting = 1'b0;
            second_read = 1'b0;
            if (val[8]) begin
              phase = SEQ_SET;
              group_idx = TOP_GROUP;
            end else begin
              phase = SEQ_IDLE;
            end
            stage(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, poll_wait);
          end
        end
        SEQ_READ: begin
          stage(KIND_WORD, row_cnt[3:0], 6'd0, val, grp, 8'd0);
          row_cnt = row_cnt + 5'd1;
          if (row_cnt < ROWS_PER_GROUP) begin
            stage(KIND_READ, row_cnt[3:0], 6'd0, 16'd0, 4'd0, 8'd0);
          end else begin
            awaiting = 1'b0;
            row_cnt = 5'd0;
            write_point(grp, 1'b0);
            stage(KIND_WAIT, 4'd0, 6'd0, 16'd0, 4'd0, step_wait);
            if (grp == 4'd0) begin
              phase = SEQ_TRANSMIT;
            end else begin
              group_idx = grp - 4'd1;
              phase = SEQ_SET;
            end
          end
        end
        default: awaiting = 1'b0;
      endcase
    end
    for (int i = 0; i < staged_n; i++) begin
      r = staged[i];
      r.last = (i == staged_n - 1);
      expected_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rcss_res_t want;
    if (!rst_ni) begin
      phase = SEQ_IDLE;
      group_idx = TOP_GROUP;
      row_cnt = 5'd0;
      awaiting = 1'b0;
      second_read = 1'b0;
      for (int i = 0; i < CACHE_ROWS; i++) dist_cache[i] = 6'd0;
      poll_wait = 8'd100;
      debounce_wait = 8'd64;
      step_wait = 8'd32;
      expected_results.delete();
      pending_o <= 0;
      reply_due_o <= 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d row %0d word 0x%0h", kind_i, row_i, card_word_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, kind_i);
          check_field("row", want.row, row_i);
          check_field("write_data", want.write_data, write_data_i);
          check_field("card_word", want.card_word, card_word_i);
          check_field("card_group", want.card_group, card_group_i);
          check_field("wait_ms", want.wait_ms, wait_ms_i);
          check_field("last", want.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) predict_item(op_i, read_data_i, timed_out_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_POLL_WAIT:     poll_wait = cfg_data_i;
          REG_DEBOUNCE_WAIT: debounce_wait = cfg_data_i;
          REG_STEP_WAIT:     step_wait = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= expected_results.size();
      reply_due_o <= awaiting;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the relay card scan sequencer: stimulus, register writes and verdict.
module testbench;
  import rcss_pkg::*;

  localparam int ITEM_TARGET   = 140;
  localparam int CFG_SPAN      = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;

  typedef enum {OP_TICK, OP_REPLY, OP_DUE, OP_NOISE} op_pick_e;
  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PATTERN} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = 1'b0;
  logic [9:0]  read_data = 10'd0;
  logic        timed_out = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  row;
  logic [5:0]  write_data;
  logic [15:0] card_word;
  logic [3:0]  card_group;
  logic [7:0]  wait_ms;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'd0;

  int          fail_count;
  int          pending;
  logic        reply_due;

  int          cycle_count = 0;
  int          burst_left = 0;
  int          sent = 0;
  int          stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic [7:0]  stall_pattern = 8'd0;

  always #1 clk = ~clk;

  relay_card_scan_sequencer_unit DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .read_data_i  (read_data),
    .timed_out_i  (timed_out),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .row_o        (row),
    .write_data_o (write_data),
    .card_word_o  (card_word),
    .card_group_o (card_group),
    .wait_ms_o    (wait_ms),
    .last_o       (last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  scan_result_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .read_data_i  (read_data),
    .timed_out_i  (timed_out),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .kind_i       (kind),
    .row_i        (row),
    .write_data_i (write_data),
    .card_word_i  (card_word),
    .card_group_i (card_group),
    .wait_ms_i    (wait_ms),
    .last_i       (last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .reply_due_o  (reply_due)
  );

  // Receiver: switch between randomly chosen stall styles.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_pattern <= 8'($urandom);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
      default:     out_stall <= stall_pattern[stall_left % 8];
    endcase
  end

  // Hold the item until accepted; the op is resolved at the drive edge so that
  // the predicted reply state is already settled.
  task automatic send_item(input op_pick_e pick, input logic [9:0] d, input logic t);
    @(negedge clk);
    case (pick)
      OP_TICK:  op <= 1'b0;
      OP_REPLY: op <= 1'b1;
      OP_DUE:   op <= reply_due;
      default:  op <= ~reply_due;
    endcase
    in_valid <= 1'b1;
    read_data <= d;
    timed_out <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending and let every expected result come out.
  task automatic drain();
    pause(1);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input int n);
    logic [7:0] v [3];
    for (int i = 0; i < 3; i++) begin
      case (n)
        0:       v[i] = 8'd255;
        1:       v[i] = 8'd1;
        default: v[i] = 8'($urandom_range(1, 255));
      endcase
    end
    write_reg(REG_POLL_WAIT, v[0]);
    write_reg(REG_DEBOUNCE_WAIT, v[1]);
    write_reg(REG_STEP_WAIT, v[2]);
  endtask

  task automatic send_random();
    logic follow;
    if (burst_left == 0) begin
      pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    // mostly follow the scan sequence; the rest are ticks or replies it must ignore
    follow = ($urandom_range(0, 99) < 85);
    send_item(follow ? OP_DUE : OP_NOISE, 10'($urandom), ($urandom_range(0, 11) == 0));
    sent++;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int setting_no;
    int next_cfg_at;
    setting_no = 0;
    next_cfg_at = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset waits.
    send_item(OP_REPLY, 10'h3FF, 1'b0);  // reply with no read outstanding
    send_item(OP_TICK, 10'h000, 1'b0);   // idle poll of row 0
    send_item(OP_TICK, 10'h3FF, 1'b1);   // tick while a reply is awaited
    send_item(OP_REPLY, 10'h000, 1'b0);  // no start bits
    send_item(OP_TICK, 10'h000, 1'b0);
    send_item(OP_REPLY, 10'h0FF, 1'b0);  // low bits only, still no start
    send_item(OP_TICK, 10'h000, 1'b0);
    send_item(OP_REPLY, 10'h100, 1'b0);  // start bit 8 -> debounce
    send_item(OP_TICK, 10'h000, 1'b0);
    send_item(OP_REPLY, 10'h100, 1'b0);  // no bit 9 -> second read
    send_item(OP_REPLY, 10'h200, 1'b0);  // second read lacks bit 8 -> back to idle
    send_item(OP_TICK, 10'h000, 1'b0);
    send_item(OP_REPLY, 10'h000, 1'b1);  // timeout counts as both start bits
    send_item(OP_TICK, 10'h000, 1'b0);
    send_item(OP_REPLY, 10'h000, 1'b1);  // timeout during debounce -> scan
    send_item(OP_REPLY, 10'h155, 1'b0);  // stray reply in group set
    send_item(OP_TICK, 10'h000, 1'b0);   // set top group's distribute bit
    send_item(OP_TICK, 10'h000, 1'b0);   // first row request
    send_item(OP_TICK, 10'h2AA, 1'b0);   // ignored, reply pending
    send_item(OP_REPLY, 10'h3FF, 1'b0);
    send_item(OP_REPLY, 10'h2AA, 1'b1);  // timed-out row word
    send_item(OP_REPLY, 10'h000, 1'b0);

    while (sent < ITEM_TARGET) begin
      if (sent >= next_cfg_at) begin
        drain();
        apply_setting(setting_no);
        setting_no++;
        next_cfg_at += CFG_SPAN;
      end
      send_random();
    end

    drain();
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
